// ----- rtl/core/cuts_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, codes and sequencer states of the catch-up tick scheduler
// no dependencies
package cuts_pkg;

  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_WINDOW = 2'd1;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 32'd1000000;
  localparam logic [PERIOD_W-1:0] FREE_WINDOW_RST = 32'd900000;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_POLL  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PDIV,
    ST_PWAIT,
    ST_FREE,
    ST_QSTART,
    ST_QWAIT,
    ST_ROUND,
    ST_FIN
  } cuts_state_e;

endpackage

// ----- rtl/core/cuts_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces: command, result and register write
// depends on cuts_pkg
interface cuts_cmd_if #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned TICK_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [TIME_BITS-1:0] now_us;
  logic [TIME_BITS-1:0] query_time_us;
  logic [TICK_BITS-1:0] query_tick;

  modport source (output valid, action, now_us, query_time_us, query_tick, input ready);
  modport sink   (input valid, action, now_us, query_time_us, query_tick, output ready);
endinterface

interface cuts_res_if #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned TICK_BITS = 32
);
  localparam int unsigned QTIME_W = (TIME_BITS < 64) ? TIME_BITS + 1 : 64;

  logic                      valid;
  logic                      ready;
  logic [TICK_BITS-1:0]      tick_count;
  logic [TICK_BITS-1:0]      ticks_advanced;
  logic                      late_flag;
  logic                      in_free_window;
  logic [TIME_BITS-1:0]      sleep_delay_us;
  logic signed [TICK_BITS:0] tick_at_query_time;
  logic signed [QTIME_W-1:0] time_of_query_tick;
  logic                      running;

  modport source (output valid, tick_count, ticks_advanced, late_flag, in_free_window,
                  sleep_delay_us, tick_at_query_time, time_of_query_tick, running,
                  input ready);
  modport sink   (input valid, tick_count, ticks_advanced, late_flag, in_free_window,
                  sleep_delay_us, tick_at_query_time, time_of_query_tick, running,
                  output ready);
endinterface

interface cuts_cfg_if;
  import cuts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PERIOD_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/cuts_div.sv -----
`timescale 1ns / 1ps
// serial restoring divider, one quotient bit per cycle, divisor of period width
// depends on cuts_pkg
module cuts_div #(
  parameter int unsigned DVD_W = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DVD_W-1:0]              dividend_i,
  input  logic [cuts_pkg::PERIOD_W-1:0] divisor_i,
  output logic                          busy_o,
  output logic [DVD_W-1:0]              quot_o,
  output logic [cuts_pkg::PERIOD_W-1:0] rem_o
);
  import cuts_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0]    dq_q, dq_d;
  logic [PERIOD_W-1:0] dvs_q, dvs_d;
  logic [PERIOD_W:0]   part;
  logic                ge;

  always_comb begin
    part   = {rem_q, dq_q[DVD_W-1]};
    ge     = part >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      dq_d   = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? PERIOD_W'(part - {1'b0, dvs_q}) : PERIOD_W'(part);
      dq_d  = {dq_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/core/cuts_mul.sv -----
`timescale 1ns / 1ps
// serial shift-add multiplier, one period bit per cycle
// depends on cuts_pkg
module cuts_mul #(
  parameter int unsigned MCD_W = 33
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [MCD_W-1:0]                       mcd_i,
  input  logic [cuts_pkg::PERIOD_W-1:0]          mlt_i,
  output logic                                   busy_o,
  output logic [MCD_W+cuts_pkg::PERIOD_W-1:0]    prod_o
);
  import cuts_pkg::*;

  localparam int unsigned PRW   = MCD_W + PERIOD_W;
  localparam int unsigned CNT_W = $clog2(PERIOD_W + 1);

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PRW-1:0]      acc_q, acc_d;
  logic [PRW-1:0]      mcd_q, mcd_d;
  logic [PERIOD_W-1:0] mlt_q, mlt_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mcd_d  = mcd_q;
    mlt_d  = mlt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(PERIOD_W);
      acc_d  = '0;
      mcd_d  = PRW'(mcd_i);
      mlt_d  = mlt_i;
    end else if (busy_q) begin
      if (mlt_q[0]) begin
        acc_d = acc_q + mcd_q;
      end
      mcd_d = {mcd_q[PRW-2:0], 1'b0};
      mlt_d = {1'b0, mlt_q[PERIOD_W-1:1]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mcd_q <= mcd_d;
    mlt_q <= mlt_d;
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/core/catch_up_tick_scheduler_unit.sv -----
`timescale 1ns / 1ps
// catch-up tick scheduler: sequencer, state registers and result register
// depends on cuts_pkg, cuts_if, cuts_div, cuts_mul
// throughput: one transaction at a time; the shared serial divider (one bit per cycle)
//   sets the pace, and a poll that advances ticks runs it twice; the next command
//   is taken the cycle after the result is registered
// reset: clock stopped, tick count and times zero, registers at their default values
module catch_up_tick_scheduler_unit #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned TICK_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  cuts_cmd_if.sink   cmd_i,
  cuts_res_if.source res_o,
  cuts_cfg_if.sink   cfg_i
);
  import cuts_pkg::*;

  localparam int unsigned TW      = TIME_BITS;
  localparam int unsigned KW      = TICK_BITS;
  localparam int unsigned QTIME_W = (TIME_BITS < 64) ? TIME_BITS + 1 : 64;
  localparam int unsigned MW      = ((TW > KW) ? TW : KW) + 1;
  localparam int unsigned PRW     = KW + 1 + PERIOD_W;
  localparam int unsigned S5      = MW + 2;
  localparam int unsigned S6      = ((TW > PRW) ? TW : PRW) + 2;

  localparam logic signed [S5-1:0] T5_HI = {{(S5-KW){1'b0}}, {KW{1'b1}}};
  localparam logic signed [S5-1:0] T5_LO = ~T5_HI;
  localparam logic signed [S6-1:0] T6_HI = {{(S6-QTIME_W+1){1'b0}}, {(QTIME_W-1){1'b1}}};
  localparam logic signed [S6-1:0] T6_LO = ~T6_HI;

  function automatic logic [TW-1:0] sat_add(logic [TW-1:0] a, logic [PERIOD_W-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + (TW+1)'(b);
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  cuts_state_e state_q, state_d;

  logic [PERIOD_W-1:0] tick_period_q, free_window_q;

  logic          started_q, started_d;
  logic [KW-1:0] tick_q, tick_d;
  logic [TW-1:0] next_q, next_d;
  logic [TW-1:0] free_end_q, free_end_d;

  logic                act_q, act_d;
  logic [TW-1:0]       now_q, now_d;
  logic [TW-1:0]       qtime_q, qtime_d;
  logic [KW-1:0]       qtick_q, qtick_d;
  logic [PERIOD_W-1:0] per_q, per_d;
  logic [TW-1:0]       d_q, d_d;
  logic [KW-1:0]       adv_q, adv_d;
  logic                late_q, late_d;
  logic                qneg_q, qneg_d;
  logic                kneg_q, kneg_d;
  logic [TW:0]         m_q, m_d;

  logic                      out_valid_q, out_valid_d;
  logic [KW-1:0]             o_tick_q, o_tick_d;
  logic [KW-1:0]             o_adv_q, o_adv_d;
  logic                      o_late_q, o_late_d;
  logic                      o_free_q, o_free_d;
  logic [TW-1:0]             o_sleep_q, o_sleep_d;
  logic signed [KW:0]        o_tqt_q, o_tqt_d;
  logic signed [QTIME_W-1:0] o_toq_q, o_toq_d;
  logic                      o_run_q, o_run_d;

  logic                in_ready;
  logic                div_start, div_busy;
  logic [TW-1:0]       div_dvd, div_quot;
  logic [PERIOD_W-1:0] div_rem;
  logic                mul_start, mul_busy;
  logic [KW:0]         mul_mcd;
  logic [PRW-1:0]      mul_prod;

  logic [MW-1:0]      q_ext, qinc;
  logic [KW:0]        base;
  logic [PERIOD_W:0]  twice_r;
  logic               rnd;
  logic signed [S5-1:0] b5, m5, v5, t5;
  logic signed [S6-1:0] n6, p6, v6, t6;
  logic               big;

  cuts_div #(
    .DVD_W (TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (per_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  cuts_mul #(
    .MCD_W (KW + 1)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcd_i   (mul_mcd),
    .mlt_i   (per_q),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    tick_d      = tick_q;
    next_d      = next_q;
    free_end_d  = free_end_q;
    act_d       = act_q;
    now_d       = now_q;
    qtime_d     = qtime_q;
    qtick_d     = qtick_q;
    per_d       = per_q;
    d_d         = d_q;
    adv_d       = adv_q;
    late_d      = late_q;
    qneg_d      = qneg_q;
    kneg_d      = kneg_q;
    m_d         = m_q;
    out_valid_d = out_valid_q;
    o_tick_d    = o_tick_q;
    o_adv_d     = o_adv_q;
    o_late_d    = o_late_q;
    o_free_d    = o_free_q;
    o_sleep_d   = o_sleep_q;
    o_tqt_d     = o_tqt_q;
    o_toq_d     = o_toq_q;
    o_run_d     = o_run_q;
    in_ready    = 1'b0;
    div_start   = 1'b0;
    div_dvd     = d_q;
    mul_start   = 1'b0;
    mul_mcd     = '0;

    q_ext   = MW'(div_quot);
    qinc    = q_ext + MW'(1);
    base    = (KW+1)'(tick_q) + (KW+1)'(1);
    twice_r = {div_rem, 1'b0};
    rnd     = qneg_q ? (twice_r > {1'b0, per_q}) : (twice_r >= {1'b0, per_q});

    b5 = S5'(base);
    m5 = S5'(m_q);
    v5 = qneg_q ? b5 - m5 : b5 + m5;
    t5 = (v5 > T5_HI) ? T5_HI : ((v5 < T5_LO) ? T5_LO : v5);

    n6  = S6'(next_q);
    p6  = S6'(mul_prod);
    v6  = kneg_q ? n6 - p6 : n6 + p6;
    big = |(mul_prod >> 64);
    if (big) begin
      t6 = kneg_q ? T6_LO : T6_HI;
    end else begin
      t6 = (v6 > T6_HI) ? T6_HI : ((v6 < T6_LO) ? T6_LO : v6);
    end

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (cmd_i.valid) begin
          act_d   = cmd_i.action;
          now_d   = cmd_i.now_us;
          qtime_d = cmd_i.query_time_us;
          qtick_d = cmd_i.query_tick;
          per_d   = (tick_period_q == '0) ? PERIOD_W'(1) : tick_period_q;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        adv_d  = '0;
        late_d = 1'b0;
        if (act_q == ACT_START) begin
          next_d    = sat_add(now_q, per_q);
          started_d = 1'b1;
          state_d   = ST_FREE;
        end else if (act_q == ACT_POLL && started_q && now_q >= next_q) begin
          d_d     = now_q - next_q;
          state_d = ST_PDIV;
        end else begin
          state_d = ST_QSTART;
        end
      end
      ST_PDIV: begin
        div_start = 1'b1;
        late_d    = ({1'b0, d_q, 3'b000} + {3'b000, d_q, 1'b0}) >= (TW+4)'(per_q);
        state_d   = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (!div_busy) begin
          adv_d   = (q_ext >= MW'({KW{1'b1}})) ? {KW{1'b1}} : qinc[KW-1:0];
          tick_d  = tick_q + qinc[KW-1:0];
          next_d  = sat_add(now_q - TW'(div_rem), per_q);
          state_d = ST_FREE;
        end
      end
      ST_FREE: begin
        free_end_d = sat_add(next_q, free_window_q);
        state_d    = ST_QSTART;
      end
      ST_QSTART: begin
        div_start = 1'b1;
        mul_start = 1'b1;
        if (qtime_q >= next_q) begin
          qneg_d  = 1'b0;
          div_dvd = qtime_q - next_q;
        end else begin
          qneg_d  = 1'b1;
          div_dvd = next_q - qtime_q;
        end
        if (qtick_q > tick_q) begin
          kneg_d  = 1'b0;
          mul_mcd = (KW+1)'(qtick_q) - (KW+1)'(tick_q) - (KW+1)'(1);
        end else begin
          kneg_d  = 1'b1;
          mul_mcd = (KW+1)'(tick_q) + (KW+1)'(1) - (KW+1)'(qtick_q);
        end
        state_d = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (!div_busy && !mul_busy) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        m_d     = {1'b0, div_quot} + (TW+1)'(rnd);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          o_tick_d    = tick_q;
          o_adv_d     = adv_q;
          o_late_d    = late_q;
          o_free_d    = now_q <= free_end_q;
          o_sleep_d   = (started_q && next_q > now_q) ? next_q - now_q : '0;
          o_tqt_d     = t5[KW:0];
          o_toq_d     = t6[QTIME_W-1:0];
          o_run_d     = started_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      started_q     <= 1'b0;
      tick_q        <= '0;
      next_q        <= '0;
      free_end_q    <= '0;
      out_valid_q   <= 1'b0;
      tick_period_q <= TICK_PERIOD_RST;
      free_window_q <= FREE_WINDOW_RST;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      tick_q      <= tick_d;
      next_q      <= next_d;
      free_end_q  <= free_end_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_TICK_PERIOD: tick_period_q <= cfg_i.data;
          REG_FREE_WINDOW: free_window_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    now_q     <= now_d;
    qtime_q   <= qtime_d;
    qtick_q   <= qtick_d;
    per_q     <= per_d;
    d_q       <= d_d;
    adv_q     <= adv_d;
    late_q    <= late_d;
    qneg_q    <= qneg_d;
    kneg_q    <= kneg_d;
    m_q       <= m_d;
    o_tick_q  <= o_tick_d;
    o_adv_q   <= o_adv_d;
    o_late_q  <= o_late_d;
    o_free_q  <= o_free_d;
    o_sleep_q <= o_sleep_d;
    o_tqt_q   <= o_tqt_d;
    o_toq_q   <= o_toq_d;
    o_run_q   <= o_run_d;
  end

  assign cmd_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid              = out_valid_q;
  assign res_o.tick_count         = o_tick_q;
  assign res_o.ticks_advanced     = o_adv_q;
  assign res_o.late_flag          = o_late_q;
  assign res_o.in_free_window     = o_free_q;
  assign res_o.sleep_delay_us     = o_sleep_q;
  assign res_o.tick_at_query_time = o_tqt_q;
  assign res_o.time_of_query_tick = o_toq_q;
  assign res_o.running            = o_run_q;

endmodule

// ----- dv/tb_catch_up_tick_scheduler_unit.sv -----
`timescale 1ns / 1ps
// self-checking testbench for catch_up_tick_scheduler_unit: random and directed start/poll
// commands against a built-in tick scheduler predictor, over several register settings
// depends on cuts_pkg, cuts_if and the rtl of catch_up_tick_scheduler_unit
module tb_catch_up_tick_scheduler_unit;
  import cuts_pkg::*;

  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned TICK_BITS = 32;
  localparam int unsigned QTIME_W   = TIME_BITS + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  typedef struct {
    logic                 action;
    logic [TIME_BITS-1:0] now_us;
    logic [TIME_BITS-1:0] query_time_us;
    logic [TICK_BITS-1:0] query_tick;
  } sched_cmd_t;

  typedef struct {
    logic [TICK_BITS-1:0]      tick_count;
    logic [TICK_BITS-1:0]      ticks_advanced;
    logic                      late_flag;
    logic                      in_free_window;
    logic [TIME_BITS-1:0]      sleep_delay_us;
    logic signed [TICK_BITS:0] tick_at_query_time;
    logic signed [QTIME_W-1:0] time_of_query_tick;
    logic                      running;
  } sched_res_t;

  typedef struct {
    logic                 started;
    logic [TICK_BITS-1:0] tick_num;
    logic [TIME_BITS-1:0] next_t;
    logic [TIME_BITS-1:0] free_end;
  } sched_state_t;

  logic clk_i;
  logic rst_ni;

  cuts_cmd_if #(.TIME_BITS(TIME_BITS), .TICK_BITS(TICK_BITS)) cmd_if ();
  cuts_res_if #(.TIME_BITS(TIME_BITS), .TICK_BITS(TICK_BITS)) res_if ();
  cuts_cfg_if cfg_if ();

  catch_up_tick_scheduler_unit #(
    .TIME_BITS(TIME_BITS),
    .TICK_BITS(TICK_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  logic [PERIOD_W-1:0] period_reg;
  logic [PERIOD_W-1:0] free_reg;
  sched_state_t        live_st;
  sched_state_t        plan_st;
  sched_cmd_t          sched_cmds_q[$];
  sched_res_t          sched_results_q[$];
  sched_cmd_t          offered_cmd;
  sched_res_t          want_res;
  int unsigned         posted_cnt;
  int unsigned         taken_cnt;
  int unsigned         mismatch_cnt;
  int unsigned         send_gap;
  int unsigned         recv_stall;
  int unsigned         hold_left;
  bit                  hold_req;
  bit                  hold_done;
  bit                  calm;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [TIME_BITS-1:0] fit_time(input logic [63:0] v);
    return (v > {16'd0, TIME_MAX}) ? TIME_MAX : v[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_BITS-1:0];
  endfunction

  function automatic logic signed [67:0] clamp_signed(input logic signed [67:0] v,
                                                      input int unsigned w);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = (68'sd1 <<< (w - 1)) - 68'sd1;
    lo = -(68'sd1 <<< (w - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one scheduler step on the given state, using the current register values
  function automatic sched_res_t step_schedule(inout sched_state_t s, input sched_cmd_t c);
    logic [63:0]        p;
    logic [63:0]        d;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        m;
    logic [63:0]        base;
    logic [63:0]        qt;
    logic signed [67:0] acc;
    sched_res_t         o;
    p = (period_reg == '0) ? 64'd1 : {32'd0, period_reg};
    o.ticks_advanced = '0;
    o.late_flag = 1'b0;
    if (c.action == ACT_START) begin
      s.next_t = fit_time({16'd0, c.now_us} + p);
      s.free_end = fit_time({16'd0, s.next_t} + {32'd0, free_reg});
      s.started = 1'b1;
    end else if (s.started && c.now_us >= s.next_t) begin
      d = {16'd0, c.now_us} - {16'd0, s.next_t};
      q = d / p;
      r = d % p;
      o.ticks_advanced = (q >= {32'd0, TICK_MAX}) ? TICK_MAX : q[TICK_BITS-1:0] + 32'd1;
      s.tick_num = s.tick_num + q[TICK_BITS-1:0] + 32'd1;
      o.late_flag = (d >= (p + 64'd9) / 64'd10);
      s.next_t = fit_time({16'd0, c.now_us} - r + p);
      s.free_end = fit_time({16'd0, s.next_t} + {32'd0, free_reg});
    end
    o.tick_count = s.tick_num;
    o.in_free_window = (c.now_us <= s.free_end);
    o.sleep_delay_us = (s.started && s.next_t > c.now_us) ? s.next_t - c.now_us : '0;
    o.running = s.started;

    // nearest tick, half up
    base = {32'd0, s.tick_num} + 64'd1;
    if (c.query_time_us >= s.next_t) begin
      d = {16'd0, c.query_time_us} - {16'd0, s.next_t};
      q = d / p;
      r = d % p;
      m = q + ((r >= p - r) ? 64'd1 : 64'd0);
      acc = $signed({4'd0, base}) + $signed({4'd0, m});
    end else begin
      d = {16'd0, s.next_t} - {16'd0, c.query_time_us};
      q = d / p;
      r = d % p;
      m = q + ((r > p - r) ? 64'd1 : 64'd0);
      acc = $signed({4'd0, base}) - $signed({4'd0, m});
    end
    acc = clamp_signed(acc, TICK_BITS + 1);
    o.tick_at_query_time = acc[TICK_BITS:0];

    // start time of the queried tick
    qt = {32'd0, c.query_tick};
    if (qt >= base) begin
      m = (qt - base) * p;
      acc = $signed({20'd0, s.next_t}) + $signed({4'd0, m});
    end else begin
      m = (base - qt) * p;
      acc = $signed({20'd0, s.next_t}) - $signed({4'd0, m});
    end
    acc = clamp_signed(acc, QTIME_W);
    o.time_of_query_tick = acc[QTIME_W-1:0];
    return o;
  endfunction

  function automatic void post_cmd(input sched_cmd_t c);
    void'(step_schedule(plan_st, c));
    sched_cmds_q.push_back(c);
    posted_cnt++;
  endfunction

  // mostly well-formed polls around the next tick, some starts and some noise
  function automatic sched_cmd_t pick_cmd();
    sched_cmd_t  c;
    logic [63:0] p;
    logic [63:0] nt;
    logic [63:0] span;
    logic [63:0] r;
    int unsigned sel;
    p = (period_reg == '0) ? 64'd1 : {32'd0, period_reg};
    nt = {16'd0, plan_st.next_t};
    sel = $urandom_range(0, 99);
    c.action = ACT_POLL;
    if (sel < 4 || (!plan_st.started && sel < 60)) begin
      c.action = ACT_START;
      case ($urandom_range(0, 9))
        0: c.now_us = TIME_MAX - 48'($urandom_range(0, 3));
        1: c.now_us = plan_st.next_t;
        2: c.now_us = rand_time();
        default: c.now_us = rand_time() >> 8;
      endcase
    end else if (sel < 9) begin
      c.action = 1'($urandom_range(0, 1));
      c.now_us = rand_time();
    end else begin
      case ($urandom_range(0, 8))
        0: begin
          span = ($urandom % p) + 64'd1;
          c.now_us = fit_time((nt > span) ? nt - span : 64'd0);
        end
        1: c.now_us = plan_st.next_t;
        2: c.now_us = fit_time(nt + (p + 64'd9) / 64'd10 - 64'd1);
        3: c.now_us = fit_time(nt + (p + 64'd9) / 64'd10);
        4: c.now_us = fit_time(nt + $urandom % p);
        5, 6: c.now_us = fit_time(nt + $urandom_range(1, 20) * p + $urandom % p);
        7: c.now_us = fit_time(nt + {16'd0, rand_time() >> 8});
        default: c.now_us = fit_time(nt + {32'd0, $urandom});
      endcase
    end

    case ($urandom_range(0, 7))
      0: c.query_time_us = rand_time();
      1: c.query_time_us = '0;
      2: c.query_time_us = TIME_MAX;
      default: begin
        case ($urandom_range(0, 3))
          0: r = p / 64'd2;
          1: r = (p + 64'd1) / 64'd2;
          2: r = p / 64'd2 + 64'd1;
          default: r = $urandom % p;
        endcase
        span = $urandom_range(0, 8) * p + r;
        if ($urandom_range(0, 1) == 1) begin
          c.query_time_us = fit_time(nt + span);
        end else begin
          c.query_time_us = fit_time((nt >= span) ? nt - span : 64'd0);
        end
      end
    endcase

    case ($urandom_range(0, 5))
      0: c.query_tick = $urandom;
      1: c.query_tick = '0;
      2: c.query_tick = TICK_MAX;
      default: c.query_tick = plan_st.tick_num + 32'd1 + 32'($urandom_range(0, 16)) - 32'd8;
    endcase
    return c;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (taken_cnt != posted_cnt || sched_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i);
    while (!(cfg_if.valid && cfg_if.ready));
    if (idx == REG_TICK_PERIOD) begin
      period_reg = val;
    end else begin
      free_reg = val;
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid         <= 1'b0;
      cmd_if.action        <= ACT_START;
      cmd_if.now_us        <= '0;
      cmd_if.query_time_us <= '0;
      cmd_if.query_tick    <= '0;
      send_gap = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        sched_results_q.push_back(step_schedule(live_st, offered_cmd));
        taken_cnt++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 3);
          cmd_if.valid <= 1'b0;
        end else if (sched_cmds_q.size() != 0) begin
          offered_cmd = sched_cmds_q.pop_front();
          cmd_if.valid         <= 1'b1;
          cmd_if.action        <= offered_cmd.action;
          cmd_if.now_us        <= offered_cmd.now_us;
          cmd_if.query_time_us <= offered_cmd.query_time_us;
          cmd_if.query_tick    <= offered_cmd.query_tick;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (sched_results_q.size() == 0) begin
          $error("result transaction with no command outstanding");
          mismatch_cnt++;
        end else begin
          want_res = sched_results_q.pop_front();
          if (res_if.tick_count !== want_res.tick_count) begin
            $error("tick_count: expected %0d, actual %0d", want_res.tick_count,
                   res_if.tick_count);
            mismatch_cnt++;
          end
          if (res_if.ticks_advanced !== want_res.ticks_advanced) begin
            $error("ticks_advanced: expected %0d, actual %0d", want_res.ticks_advanced,
                   res_if.ticks_advanced);
            mismatch_cnt++;
          end
          if (res_if.late_flag !== want_res.late_flag) begin
            $error("late_flag: expected %0d, actual %0d", want_res.late_flag,
                   res_if.late_flag);
            mismatch_cnt++;
          end
          if (res_if.in_free_window !== want_res.in_free_window) begin
            $error("in_free_window: expected %0d, actual %0d", want_res.in_free_window,
                   res_if.in_free_window);
            mismatch_cnt++;
          end
          if (res_if.sleep_delay_us !== want_res.sleep_delay_us) begin
            $error("sleep_delay_us: expected %0d, actual %0d", want_res.sleep_delay_us,
                   res_if.sleep_delay_us);
            mismatch_cnt++;
          end
          if (res_if.tick_at_query_time !== want_res.tick_at_query_time) begin
            $error("tick_at_query_time: expected %0d, actual %0d",
                   want_res.tick_at_query_time, res_if.tick_at_query_time);
            mismatch_cnt++;
          end
          if (res_if.time_of_query_tick !== want_res.time_of_query_tick) begin
            $error("time_of_query_tick: expected %0d, actual %0d",
                   want_res.time_of_query_tick, res_if.time_of_query_tick);
            mismatch_cnt++;
          end
          if (res_if.running !== want_res.running) begin
            $error("running: expected %0d, actual %0d", want_res.running, res_if.running);
            mismatch_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 399;
        res_if.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(0, 3);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [PERIOD_W-1:0] per;
    logic [PERIOD_W-1:0] fw;
    cmd_if.valid         = 1'b0;
    cmd_if.action        = ACT_START;
    cmd_if.now_us        = '0;
    cmd_if.query_time_us = '0;
    cmd_if.query_tick    = '0;
    res_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_TICK_PERIOD;
    cfg_if.data          = '0;
    rst_ni               = 1'b0;
    period_reg           = TICK_PERIOD_RST;
    free_reg             = FREE_WINDOW_RST;
    live_st              = '{started: 1'b0, tick_num: '0, next_t: '0, free_end: '0};
    plan_st              = live_st;
    posted_cnt           = 0;
    taken_cnt            = 0;
    mismatch_cnt         = 0;
    hold_req             = 1'b0;
    hold_done            = 1'b0;
    calm                 = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed commands at the reset register values (one tick = 1 s)
    post_cmd(sched_cmd_t'{ACT_POLL, 48'd0, 48'd0, 32'd0});
    post_cmd(sched_cmd_t'{ACT_POLL, TIME_MAX, TIME_MAX, TICK_MAX});
    post_cmd(sched_cmd_t'{ACT_START, 48'd1000, 48'd0, 32'd0});
    post_cmd(sched_cmd_t'{ACT_POLL, plan_st.next_t - 48'd1, plan_st.next_t + 48'd500000,
                          32'd1});
    post_cmd(sched_cmd_t'{ACT_POLL, plan_st.next_t, plan_st.next_t - 48'd500000, 32'd0});
    post_cmd(sched_cmd_t'{ACT_POLL, plan_st.next_t + 48'd99999,
                          plan_st.next_t + 48'd499999, 32'd2});
    post_cmd(sched_cmd_t'{ACT_POLL, plan_st.next_t + 48'd100000,
                          plan_st.next_t - 48'd500001, 32'd5});
    post_cmd(sched_cmd_t'{ACT_POLL, plan_st.next_t + 48'd5000003, 48'd0, TICK_MAX});
    post_cmd(sched_cmd_t'{ACT_START, 48'd5000000, 48'd5000000, 32'd0});
    post_cmd(sched_cmd_t'{ACT_POLL, 48'd5999999, 48'd5999999, 32'h8000_0000});
    post_cmd(sched_cmd_t'{ACT_START, TIME_MAX - 48'd10, TIME_MAX, 32'd7});
    post_cmd(sched_cmd_t'{ACT_POLL, TIME_MAX, 48'd0, 32'd0});
    post_cmd(sched_cmd_t'{ACT_POLL, TIME_MAX, TIME_MAX, TICK_MAX});
    post_cmd(sched_cmd_t'{ACT_START, 48'd0, 48'd1, 32'd1});
    post_cmd(sched_cmd_t'{ACT_POLL, 48'd0, 48'd0, 32'd0});

    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      case (ph)
        0: begin per = '0;        fw = 32'd1;    end
        1: begin per = 32'd1;     fw = '1;       end
        2: begin per = '1;        fw = '1;       end
        3: begin per = '1;        fw = 32'd1;    end
        4: begin per = TICK_PERIOD_RST; fw = FREE_WINDOW_RST; end
        default: begin
          case ($urandom_range(0, 2))
            0: per = $urandom_range(2, 100);
            1: per = $urandom_range(1000, 10000000);
            default: per = $urandom;
          endcase
          fw = (per > 32'd1) ? $urandom_range(1, per) : 32'd1;
        end
      endcase
      write_reg(REG_TICK_PERIOD, per);
      write_reg(REG_FREE_WINDOW, fw);
      if (ph == 9) calm = 1'b1;
      plan_st = live_st;
      repeat (200) post_cmd(pick_cmd());
      if (ph == 4) hold_req = 1'b1;
    end

    wait_idle();
    repeat (120) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_catch_up_tick_scheduler_unit OK");
    end else begin
      $display("tb_catch_up_tick_scheduler_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_catch_up_tick_scheduler_unit NOT OK");
    $finish;
  end

endmodule
